@@ hw/rtl/mfpl_pkg.sv @@
// ---------------------------------------------------------------------------
// Marker-framed flash page loader package
// Shared types, marker constants and the start marker lookup.
// ---------------------------------------------------------------------------
package mfpl_pkg;

  typedef enum logic [1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_START = 2'd1,
    STATUS_END   = 2'd2
  } status_e;

  localparam logic [3:0]  START_MARKER_LEN = 4'd11;
  localparam logic [3:0]  END_HIST_LEN     = 4'd8;
  localparam logic [71:0] END_MARKER       = "flash end";

  function automatic logic [7:0] start_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "f";
      4'd1:    c = "l";
      4'd2:    c = "a";
      4'd3:    c = "s";
      4'd4:    c = "h";
      4'd5:    c = " ";
      4'd6:    c = "s";
      4'd7:    c = "t";
      4'd8:    c = "a";
      4'd9:    c = "r";
      4'd10:   c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/mfpl_rx_if.sv @@
// ---------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received byte per transaction.
// ---------------------------------------------------------------------------
interface mfpl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/mfpl_res_if.sv @@
// ---------------------------------------------------------------------------
// Loader result channel
// Valid/ready channel that carries one loader result per transaction.
// ---------------------------------------------------------------------------
interface mfpl_res_if;
  logic                 valid;
  logic                 ready;
  mfpl_pkg::status_e    status;
  logic                 data_valid;
  logic [7:0]           data_byte;
  logic [7:0]           data_offset;
  logic                 commit_valid;
  logic [31:0]          commit_address;
  logic [8:0]           commit_length;
  logic [31:0]          bytes_committed;
  logic                 in_receive;

  modport source (
    output valid, output status, output data_valid, output data_byte,
    output data_offset, output commit_valid, output commit_address,
    output commit_length, output bytes_committed, output in_receive,
    input ready
  );
  modport sink (
    input valid, input status, input data_valid, input data_byte,
    input data_offset, input commit_valid, input commit_address,
    input commit_length, input bytes_committed, input in_receive,
    output ready
  );
endinterface

@@ hw/rtl/marker_framed_flash_page_loader_core.sv @@
// ---------------------------------------------------------------------------
// Marker-framed flash page loader core
// Frames an image between text markers and emits page stores and commits.
// ---------------------------------------------------------------------------
// Each received byte yields exactly one result transaction. A byte is first
// captured in an input register, then evaluated against the marker and page
// state combinationally and written to the result register, so one byte per
// clock is sustained while the result channel accepts; a stalled result
// holds the byte in the input register. The base address register is
// sampled only when the start marker completes.
module marker_framed_flash_page_loader_core #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  mfpl_rx_if.sink            rx_i,
  mfpl_res_if.source         res_o
);

  localparam int unsigned BufW = $clog2(PAGE_BYTES);
  localparam logic [BufW-1:0] BufLast = BufW'(PAGE_BYTES - 1);
  localparam logic [31:0] PageLen = 32'(PAGE_BYTES);

  logic [31:0]     base_q;
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            recv_q, recv_d;
  logic [3:0]      start_cnt_q, start_cnt_d;
  logic [63:0]     hist_q, hist_d;
  logic [3:0]      hist_fill_q, hist_fill_d;
  logic [31:0]     addr_q, addr_d;
  logic [31:0]     total_q, total_d;
  logic [BufW-1:0] buf_q, buf_d;

  logic               res_valid_q;
  mfpl_pkg::status_e  status_q, status_d;
  logic               dvalid_q, dvalid_d;
  logic [7:0]         dbyte_q, dbyte_d;
  logic [7:0]         doff_q, doff_d;
  logic               cvalid_q, cvalid_d;
  logic [31:0]        caddr_q, caddr_d;
  logic [8:0]         clen_q, clen_d;

  logic        out_free;
  logic        advance;
  logic [31:0] buf_ext;

  assign out_free   = !res_valid_q || res_o.ready;
  assign advance    = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || advance;
  assign buf_ext    = 32'(buf_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_comb begin
    recv_d      = recv_q;
    start_cnt_d = start_cnt_q;
    hist_d      = hist_q;
    hist_fill_d = hist_fill_q;
    addr_d      = addr_q;
    total_d     = total_q;
    buf_d       = buf_q;
    status_d    = mfpl_pkg::STATUS_NONE;
    dvalid_d    = 1'b0;
    dbyte_d     = '0;
    doff_d      = '0;
    cvalid_d    = 1'b0;
    caddr_d     = '0;
    clen_d      = '0;

    if (!recv_q) begin
      if (in_byte_q == mfpl_pkg::start_char(start_cnt_q)) begin
        if (start_cnt_q == mfpl_pkg::START_MARKER_LEN - 4'd1) begin
          recv_d      = 1'b1;
          addr_d      = base_q;
          total_d     = '0;
          buf_d       = '0;
          hist_fill_d = '0;
          start_cnt_d = '0;
          status_d    = mfpl_pkg::STATUS_START;
        end else begin
          start_cnt_d = start_cnt_q + 4'd1;
        end
      end else begin
        start_cnt_d = (in_byte_q == mfpl_pkg::start_char(4'd0)) ? 4'd1 : 4'd0;
      end
    end else begin
      hist_d = {hist_q[55:0], in_byte_q};
      if (hist_fill_q != mfpl_pkg::END_HIST_LEN) begin
        hist_fill_d = hist_fill_q + 4'd1;
      end
      if (hist_fill_q == mfpl_pkg::END_HIST_LEN &&
          {hist_q, in_byte_q} == mfpl_pkg::END_MARKER) begin
        recv_d   = 1'b0;
        status_d = mfpl_pkg::STATUS_END;
        if (buf_q != '0) begin
          cvalid_d = 1'b1;
          caddr_d  = addr_q;
          clen_d   = buf_ext[8:0];
          addr_d   = addr_q + buf_ext;
          total_d  = total_q + buf_ext;
          buf_d    = '0;
        end
      end else begin
        dvalid_d = 1'b1;
        dbyte_d  = in_byte_q;
        doff_d   = buf_ext[7:0];
        if (buf_q == BufLast) begin
          cvalid_d = 1'b1;
          caddr_d  = addr_q;
          clen_d   = PageLen[8:0];
          addr_d   = addr_q + PageLen;
          total_d  = total_q + PageLen;
          buf_d    = '0;
        end else begin
          buf_d = buf_q + BufW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q      <= 1'b0;
      start_cnt_q <= '0;
      hist_q      <= '0;
      hist_fill_q <= '0;
      addr_q      <= '0;
      total_q     <= '0;
      buf_q       <= '0;
    end else if (advance) begin
      recv_q      <= recv_d;
      start_cnt_q <= start_cnt_d;
      hist_q      <= hist_d;
      hist_fill_q <= hist_fill_d;
      addr_q      <= addr_d;
      total_q     <= total_d;
      buf_q       <= buf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      dvalid_q <= dvalid_d;
      dbyte_q  <= dbyte_d;
      doff_q   <= doff_d;
      cvalid_q <= cvalid_d;
      caddr_q  <= caddr_d;
      clen_q   <= clen_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.status          = status_q;
  assign res_o.data_valid      = dvalid_q;
  assign res_o.data_byte       = dbyte_q;
  assign res_o.data_offset     = doff_q;
  assign res_o.commit_valid    = cvalid_q;
  assign res_o.commit_address  = caddr_q;
  assign res_o.commit_length   = clen_q;
  assign res_o.bytes_committed = total_q;
  assign res_o.in_receive      = recv_q;

  // Stored bytes only occur while an image is being received.
  a_data_in_receive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data_valid |-> res_o.in_receive)
    else $error("data store outside receive mode");

  // A completed start marker opens a fresh image with nothing committed.
  a_start_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == mfpl_pkg::STATUS_START |->
      res_o.in_receive && res_o.bytes_committed == 32'd0 && !res_o.commit_valid)
    else $error("start marker did not open a fresh image");

  // A commit never programs an empty page.
  a_commit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.commit_valid |-> res_o.commit_length != 9'd0 ||
      PageLen[8:0] == 9'd0)
    else $error("empty page commit");

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// Marker-framed flash page loader testbench
// Sends byte streams framed by start and end markers, with random gaps and
// back-pressure on both channels, and checks every result transaction
// against an independent prediction of the page stores and commits.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PAGE         = 256;
  localparam int unsigned START_N      = 11;
  localparam int unsigned END_N        = 9;
  localparam logic [87:0] START_TEXT   = "flash start";
  localparam logic [71:0] END_TEXT     = "flash end";
  localparam int unsigned ITEM_GOAL    = 450;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    mfpl_pkg::status_e status;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [7:0]        data_offset;
    logic              commit_valid;
    logic [31:0]       commit_address;
    logic [8:0]        commit_length;
    logic [31:0]       bytes_committed;
    logic              in_receive;
  } loader_out_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        known;
    loader_out_t res;
  } dir_row_t;

  localparam loader_out_t NO_OUT = '0;
  localparam int unsigned DIR_N = 25;

  // The directed rows run with the image base at its top value.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h00, 1'b1, NO_OUT},
    '{"f", 1'b0, NO_OUT},
    '{"l", 1'b0, NO_OUT},
    '{"f", 1'b0, NO_OUT},
    '{"l", 1'b0, NO_OUT},
    '{"a", 1'b0, NO_OUT},
    '{"s", 1'b0, NO_OUT},
    '{"h", 1'b0, NO_OUT},
    '{" ", 1'b0, NO_OUT},
    '{"s", 1'b0, NO_OUT},
    '{"t", 1'b0, NO_OUT},
    '{"a", 1'b0, NO_OUT},
    '{"r", 1'b0, NO_OUT},
    '{"t", 1'b1, '{mfpl_pkg::STATUS_START, 1'b0, 8'h00, 8'd0, 1'b0, 32'h0, 9'd0,
                   32'd0, 1'b1}},
    '{8'h00, 1'b1, '{mfpl_pkg::STATUS_NONE, 1'b1, 8'h00, 8'd0, 1'b0, 32'h0, 9'd0,
                     32'd0, 1'b1}},
    '{8'hFF, 1'b1, '{mfpl_pkg::STATUS_NONE, 1'b1, 8'hFF, 8'd1, 1'b0, 32'h0, 9'd0,
                     32'd0, 1'b1}},
    '{"f", 1'b0, NO_OUT},
    '{"l", 1'b0, NO_OUT},
    '{"a", 1'b0, NO_OUT},
    '{"s", 1'b0, NO_OUT},
    '{"h", 1'b0, NO_OUT},
    '{" ", 1'b0, NO_OUT},
    '{"e", 1'b0, NO_OUT},
    '{"n", 1'b0, NO_OUT},
    '{"d", 1'b1, '{mfpl_pkg::STATUS_END, 1'b0, 8'h00, 8'd0, 1'b1, 32'hFFFF_FFFF, 9'd10,
                   32'd10, 1'b0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  mfpl_rx_if  rx_if ();
  mfpl_res_if res_if ();

  marker_framed_flash_page_loader_core #(
    .PAGE_BYTES(PAGE)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_if.sink),
    .res_o      (res_if.source)
  );

  logic [31:0] image_base;
  logic [31:0] next_addr;
  logic [31:0] total_bytes;
  logic        receiving;
  int unsigned start_hits;
  int unsigned window_fill;
  int unsigned page_fill;
  logic [7:0]  tail_win [END_N];

  loader_out_t loader_out_q [$];
  logic [7:0]  burst_q [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void flush_page(inout loader_out_t o);
    if (page_fill != 0) begin
      o.commit_valid   = 1'b1;
      o.commit_address = next_addr;
      o.commit_length  = page_fill[8:0];
      next_addr        = next_addr + page_fill;
      total_bytes      = total_bytes + page_fill;
      page_fill        = 0;
    end
  endfunction

  function automatic loader_out_t step_loader(input logic [7:0] b);
    loader_out_t o;
    logic [71:0] seen;
    int          i;
    o    = '0;
    seen = '0;
    if (!receiving) begin
      if (start_hits < START_N && b == START_TEXT[8*(START_N-1-start_hits) +: 8]) begin
        start_hits++;
        if (start_hits == START_N) begin
          receiving   = 1'b1;
          next_addr   = image_base;
          total_bytes = '0;
          page_fill   = 0;
          window_fill = 0;
          for (i = 0; i < END_N; i++) tail_win[i] = 8'h00;
          start_hits  = 0;
          o.status    = mfpl_pkg::STATUS_START;
        end
      end else begin
        start_hits = (b == START_TEXT[87 -: 8]) ? 1 : 0;
      end
    end else begin
      if (window_fill < END_N) begin
        tail_win[window_fill] = b;
        window_fill++;
      end else begin
        for (i = 0; i < END_N - 1; i++) tail_win[i] = tail_win[i + 1];
        tail_win[END_N - 1] = b;
      end
      for (i = 0; i < END_N; i++) seen[8*(END_N-1-i) +: 8] = tail_win[i];
      if (window_fill >= END_N && seen == END_TEXT) begin
        flush_page(o);
        receiving = 1'b0;
        o.status  = mfpl_pkg::STATUS_END;
      end else begin
        o.data_valid  = 1'b1;
        o.data_byte   = b;
        o.data_offset = page_fill[7:0];
        page_fill++;
        if (page_fill >= PAGE) flush_page(o);
      end
    end
    o.bytes_committed = total_bytes;
    o.in_receive      = receiving;
    return o;
  endfunction

  function automatic string describe(input loader_out_t o);
    return $sformatf("status=%0d data=%b/%h@%0d commit=%b/%h+%0d total=%0d rx=%b",
                     o.status, o.data_valid, o.data_byte, o.data_offset, o.commit_valid,
                     o.commit_address, o.commit_length, o.bytes_committed, o.in_receive);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic known, input loader_out_t typed);
    loader_out_t want;
    while (!(items_sent >= 150 && items_sent < 240) && $urandom_range(99) < 13) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    want = step_loader(b);
    loader_out_q.push_back(known ? typed : want);
    items_sent++;
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    while (loader_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_image_base(input logic [31:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    image_base = v;
  endtask

  task automatic push_text(input string s, input int n);
    int k;
    for (k = 0; k < n; k++) burst_q.push_back(s[k]);
  endtask

  task automatic push_noise(input int n);
    string alphabet;
    int    k;
    alphabet = "flash startend";
    for (k = 0; k < n; k++) begin
      if ($urandom_range(1) == 0) burst_q.push_back(8'($urandom_range(255)));
      else burst_q.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
    end
  endtask

  // Image payload with occasional broken end markers and embedded start text.
  task automatic push_payload(input int n);
    int count;
    int pick;
    int len;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        len = $urandom_range(8, 1);
        push_text("flash end", len);
        count += len;
      end else if (pick < 12) begin
        push_text("flash start", 11);
        count += 11;
      end else begin
        burst_q.push_back(8'($urandom_range(255)));
        count++;
      end
    end
  endtask

  task automatic send_burst();
    int k;
    for (k = 0; k < burst_q.size(); k++) send_byte(burst_q[k], 1'b0, NO_OUT);
    burst_q.delete();
  endtask

  initial begin
    int unsigned hold_left;
    logic        held;
    loader_out_t got;
    loader_out_t want;
    hold_left = 0;
    held      = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.status          = res_if.status;
        got.data_valid      = res_if.data_valid;
        got.data_byte       = res_if.data_byte;
        got.data_offset     = res_if.data_offset;
        got.commit_valid    = res_if.commit_valid;
        got.commit_address  = res_if.commit_address;
        got.commit_length   = res_if.commit_length;
        got.bytes_committed = res_if.bytes_committed;
        got.in_receive      = res_if.in_receive;
        results_seen++;
        if (loader_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d not expected: %s", results_seen, describe(got));
          end
        end else begin
          want = loader_out_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (!held && results_seen >= 60) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= 150 && results_seen < 240) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[marker_framed_flash_page_loader_core] ERROR");
    $finish;
  end

  initial begin
    int unsigned row;
    int unsigned kind;
    logic [31:0] base;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    image_base  = '0;
    next_addr   = '0;
    total_bytes = '0;
    receiving   = 1'b0;
    start_hits  = 0;
    window_fill = 0;
    page_fill   = 0;
    for (row = 0; row < END_N; row++) tail_win[row] = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_image_base(32'hFFFF_FFFF);
    for (row = 0; row < DIR_N; row++) begin
      send_byte(DIR_TAB[row].rx_byte, DIR_TAB[row].known, DIR_TAB[row].res);
    end

    // A full page commits on the last byte before the end marker completes,
    // so the end finds an empty page; the address wraps past the top.
    set_image_base(32'hFFFF_FF80);
    push_text("flash start", 11);
    push_noise(0);
    burst_q.push_back(8'h00);
    burst_q.push_back(8'hFF);
    while (burst_q.size() < START_N + PAGE - 8) burst_q.push_back(8'($urandom_range(255)));
    push_text("flash end", 9);
    send_burst();

    set_image_base(32'h0000_0000);
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(2) == 0) begin
        base = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom();
        set_image_base(base);
      end
      kind = $urandom_range(3);
      if (kind == 0) begin
        push_noise($urandom_range(30, 10));
      end else begin
        push_text("flash start", $urandom_range(10));
        push_text("flash start", 11);
        push_payload($urandom_range(40));
        if ($urandom_range(9) != 0) push_text("flash end", 9);
      end
      send_burst();
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && loader_out_q.size() == 0) begin
      $display("[marker_framed_flash_page_loader_core] OK");
    end else begin
      $display("[marker_framed_flash_page_loader_core] ERROR");
    end
    $finish;
  end

endmodule
